[design/dsc_pkg.sv]
// Shared types and constants for the dial string cleaner.
package dsc_pkg;

    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 12;
    localparam int BYTE_W  = 8;

    localparam logic [COUNT_W-1:0] C_MAX_KEPT_RST = 12'd255;

    // UTF-8 fullwidth form markers
    localparam logic [BYTE_W-1:0] C_LEAD_FW     = 8'hEF;
    localparam logic [BYTE_W-1:0] C_SECOND_FW   = 8'hBC;
    localparam logic [BYTE_W-1:0] C_SECOND_HALF = 8'hBD;
    localparam logic [BYTE_W-1:0] C_FW_OFFSET   = 8'h60;
    localparam logic [BYTE_W-1:0] C_FW_DIGIT_LO = 8'h90;
    localparam logic [BYTE_W-1:0] C_FW_DIGIT_HI = 8'h99;
    localparam logic [BYTE_W-1:0] C_FW_PLUS     = 8'h8B;
    localparam logic [BYTE_W-1:0] C_FW_STAR     = 8'h8A;
    localparam logic [BYTE_W-1:0] C_FW_HASH     = 8'h83;
    localparam logic [BYTE_W-1:0] C_FW_COMMA    = 8'h8C;
    localparam logic [BYTE_W-1:0] C_FW_SEMI     = 8'h9B;

    // ASCII characters that are kept
    localparam logic [CHAR_W-1:0] C_ASC_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] C_ASC_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] C_ASC_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] C_ASC_STAR  = 7'h2A;
    localparam logic [CHAR_W-1:0] C_ASC_HASH  = 7'h23;
    localparam logic [CHAR_W-1:0] C_ASC_COMMA = 7'h2C;
    localparam logic [CHAR_W-1:0] C_ASC_SEMI  = 7'h3B;

    typedef enum logic [1:0] {
        STEP_NONE   = 2'd0,
        STEP_SECOND = 2'd1,
        STEP_THIRD  = 2'd2
    } t_seq_step;

    typedef enum logic [1:0] {
        SK_NONE  = 2'd0,
        SK_BC    = 2'd1,
        SK_BD    = 2'd2,
        SK_OTHER = 2'd3
    } t_second_kind;

    typedef struct packed {
        logic [1:0]   bytes_left;
        t_seq_step    seq_step;
        logic         lead_fw;
        t_second_kind second_kind;
    } t_seq_state;

    localparam t_seq_state C_SEQ_IDLE = '{
        bytes_left:  2'd0,
        seq_step:    STEP_NONE,
        lead_fw:     1'b0,
        second_kind: SK_NONE
    };

    typedef struct packed {
        logic               is_end;
        logic [COUNT_W-1:0] kept_count;
        logic [CHAR_W-1:0]  out_char;
    } t_result;

endpackage

[design/dsc_decode.sv]
// UTF-8 byte classifier: next sequence state and kept character for one byte.
module dsc_decode
    import dsc_pkg::*;
(
    input  t_seq_state              i_state,
    input  logic [BYTE_W-1:0]       i_byte,
    output t_seq_state              o_state,
    output logic                    o_keep,
    output logic [CHAR_W-1:0]       o_char
);

    logic              ascii_keep;
    logic              fw_keep;
    logic [CHAR_W-1:0] fw_char;

    always_comb begin
        ascii_keep = 1'b0;
        if (i_byte[6:0] >= C_ASC_ZERO && i_byte[6:0] <= C_ASC_NINE) begin
            ascii_keep = 1'b1;
        end else if (i_byte[6:0] == C_ASC_PLUS || i_byte[6:0] == C_ASC_HASH ||
                     i_byte[6:0] == C_ASC_STAR || i_byte[6:0] == C_ASC_SEMI ||
                     i_byte[6:0] == C_ASC_COMMA) begin
            ascii_keep = 1'b1;
        end
    end

    always_comb begin
        fw_keep = 1'b1;
        fw_char = '0;
        if (i_byte >= C_FW_DIGIT_LO && i_byte <= C_FW_DIGIT_HI) begin
            fw_char = CHAR_W'(i_byte - C_FW_OFFSET);
        end else begin
            case (i_byte)
                C_FW_PLUS:  fw_char = C_ASC_PLUS;
                C_FW_STAR:  fw_char = C_ASC_STAR;
                C_FW_HASH:  fw_char = C_ASC_HASH;
                C_FW_COMMA: fw_char = C_ASC_COMMA;
                C_FW_SEMI:  fw_char = C_ASC_SEMI;
                default:    fw_keep = 1'b0;
            endcase
        end
    end

    always_comb begin
        o_state = i_state;
        o_keep  = 1'b0;
        o_char  = '0;
        if (i_state.bytes_left != 2'd0) begin
            case (i_state.seq_step)
                STEP_SECOND: begin
                    if (i_byte == C_SECOND_FW) begin
                        o_state.second_kind = SK_BC;
                    end else if (i_byte == C_SECOND_HALF) begin
                        o_state.second_kind = SK_BD;
                    end else begin
                        o_state.second_kind = SK_OTHER;
                    end
                    o_state.seq_step = STEP_THIRD;
                end
                STEP_THIRD: begin
                    if (i_state.lead_fw && i_state.second_kind == SK_BC) begin
                        o_keep = fw_keep;
                        o_char = fw_char;
                    end
                    o_state.seq_step = STEP_NONE;
                end
                default: ;
            endcase
            o_state.bytes_left = i_state.bytes_left - 2'd1;
            if (i_state.bytes_left == 2'd1) begin
                o_state = C_SEQ_IDLE;
            end
        end else if (!i_byte[7]) begin
            o_keep = ascii_keep;
            o_char = i_byte[6:0];
        end else if (i_byte[7:5] == 3'b110) begin
            o_state.bytes_left = 2'd1;
        end else if (i_byte[7:4] == 4'b1110) begin
            o_state.bytes_left = 2'd2;
            o_state.seq_step   = STEP_SECOND;
            o_state.lead_fw    = (i_byte == C_LEAD_FW);
        end else if (i_byte[7:3] == 5'b11110) begin
            o_state.bytes_left = 2'd3;
        end
    end

endmodule

[design/dsc_out_stage.sv]
// Result register: holds one word until the downstream side takes it.
module dsc_out_stage
    import dsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_free
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[design/dial_string_cleaner.sv]
// Dial string cleaner top level: input register, decode, count limit, result register.
//
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tdata[7:0] in_byte, tlast end_of_string
//  m_axis    out  tvalid/tready        tdata[6:0] out_char, [18:7] kept_count; tlast is_end
//  cfg       in   wen                  wdata[11:0] max_kept
//
// One word per cycle sustained while the result side is not stalled.
// A word is decoded as it moves from the input register to the result register.
// A stalled result register holds the input register, which drops tready.
// Synchronous active-low reset clears sequence state and count; max_kept goes to 255.
module dial_string_cleaner
    import dsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // [7:0] in_byte
    input  logic               i_s_axis_tlast,   // end_of_string
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [23:0]        o_m_axis_tdata,   // [6:0] out_char, [18:7] kept_count
    output logic               o_m_axis_tlast,   // is_end
    input  logic               i_cfg_wen,
    input  logic [COUNT_W-1:0] i_cfg_wdata       // max_kept
);

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_last;
    t_seq_state         r_seq;
    t_seq_state         n_seq;
    logic [COUNT_W-1:0] r_kept_total;
    logic [COUNT_W-1:0] n_kept_total;
    logic [COUNT_W-1:0] r_max_kept;

    t_seq_state         dec_state;
    logic               dec_keep;
    logic [CHAR_W-1:0]  dec_char;

    logic               out_free;
    logic               advance;
    logic               emit;
    t_result            res_in;
    t_result            res_out;

    dsc_decode u_decode (
        .i_state (r_seq),
        .i_byte  (r_in_byte),
        .o_state (dec_state),
        .o_keep  (dec_keep),
        .o_char  (dec_char)
    );

    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    always_comb begin
        n_seq        = r_seq;
        n_kept_total = r_kept_total;
        emit         = 1'b0;
        res_in       = '0;
        if (r_in_last) begin
            emit              = 1'b1;
            res_in.is_end     = 1'b1;
            res_in.kept_count = r_kept_total;
            n_seq             = C_SEQ_IDLE;
            n_kept_total      = '0;
        end else begin
            n_seq = dec_state;
            if (dec_keep && r_kept_total < r_max_kept) begin
                emit              = 1'b1;
                n_kept_total      = r_kept_total + COUNT_W'(1);
                res_in.out_char   = dec_char;
                res_in.kept_count = n_kept_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_seq        <= C_SEQ_IDLE;
            r_kept_total <= '0;
            r_max_kept   <= C_MAX_KEPT_RST;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_seq        <= n_seq;
                r_kept_total <= n_kept_total;
            end
            if (i_cfg_wen) begin
                r_max_kept <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    dsc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (res_in),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_result (res_out),
        .o_free   (out_free)
    );

    assign o_m_axis_tdata = {5'b0, res_out.kept_count, res_out.out_char};
    assign o_m_axis_tlast = res_out.is_end;

    // kept characters are never zero and always carry a nonzero count
    a_char_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |->
            o_m_axis_tdata[6:0] != 7'd0 && o_m_axis_tdata[18:7] != 12'd0)
        else $error("kept word with zero char or count");

    // end word carries no character
    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata[6:0] == 7'd0)
        else $error("end word with nonzero char");

    // terminator clears the string state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_kept_total == '0 && r_seq == C_SEQ_IDLE)
        else $error("state not cleared after terminator");

    // an empty result register never back-pressures the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

[dv/tb_top.sv]
// Testbench for dial_string_cleaner: directed and random UTF-8 strings checked against a cycle-free cleaning model.
`timescale 1ns / 100ps

module tb_top;
    import dsc_pkg::*;

    localparam int IDLE_PCT       = 23;
    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_ITEMS   = 950;
    localparam int SETTLE_CYCLES  = 4;
    localparam int SHOWN_MISMATCH = 10;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata = '0;   // [7:0] in_byte
    logic               i_s_axis_tlast = 1'b0; // end_of_string
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [23:0]        o_m_axis_tdata;        // [6:0] out_char, [18:7] kept_count
    logic               o_m_axis_tlast;        // is_end
    logic               i_cfg_wen = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;      // max_kept

    dial_string_cleaner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cleaning model state
    logic [1:0]         cont_left;
    t_seq_step          seq_pos;
    logic               lead_was_ef;
    t_second_kind       second_class;
    logic [COUNT_W-1:0] kept_so_far;
    logic [COUNT_W-1:0] kept_limit = C_MAX_KEPT_RST;

    t_result cleaned_q[$];
    t_result want;
    int      mismatches = 0;
    int      words_sent = 0;
    int      stuck_cycles = 0;
    bit      steady = 1'b0;

    function automatic logic [CHAR_W-1:0] ascii_keep(input logic [7:0] b);
        if (b[7])
            return '0;
        if ((b[6:0] >= C_ASC_ZERO && b[6:0] <= C_ASC_NINE) || b[6:0] == C_ASC_PLUS ||
            b[6:0] == C_ASC_HASH || b[6:0] == C_ASC_STAR || b[6:0] == C_ASC_SEMI ||
            b[6:0] == C_ASC_COMMA)
            return b[6:0];
        return '0;
    endfunction

    function automatic logic [CHAR_W-1:0] fullwidth_keep(input logic [7:0] third);
        logic [7:0] half;
        half = third - C_FW_OFFSET;
        if (third >= C_FW_DIGIT_LO && third <= C_FW_DIGIT_HI)
            return half[CHAR_W-1:0];
        case (third)
            C_FW_PLUS:  return C_ASC_PLUS;
            C_FW_STAR:  return C_ASC_STAR;
            C_FW_HASH:  return C_ASC_HASH;
            C_FW_COMMA: return C_ASC_COMMA;
            C_FW_SEMI:  return C_ASC_SEMI;
            default:    return '0;
        endcase
    endfunction

    task automatic clear_seq();
        cont_left    = '0;
        seq_pos      = STEP_NONE;
        lead_was_ef  = 1'b0;
        second_class = SK_NONE;
    endtask

    task automatic clean_byte(input logic [7:0] b, input logic eos);
        logic [CHAR_W-1:0] ch;
        t_result           r;
        ch = '0;
        if (eos) begin
            r = '{is_end: 1'b1, kept_count: kept_so_far, out_char: '0};
            cleaned_q.push_back(r);
            clear_seq();
            kept_so_far = '0;
            return;
        end
        if (cont_left != 0) begin
            if (seq_pos == STEP_SECOND) begin
                second_class = (b == C_SECOND_FW) ? SK_BC :
                               (b == C_SECOND_HALF) ? SK_BD : SK_OTHER;
                seq_pos = STEP_THIRD;
            end else if (seq_pos == STEP_THIRD) begin
                if (lead_was_ef && second_class == SK_BC)
                    ch = fullwidth_keep(b);
                seq_pos = STEP_NONE;
            end
            cont_left = cont_left - 2'd1;
            if (cont_left == 0)
                clear_seq();
        end else if (!b[7]) begin
            ch = ascii_keep(b);
        end else if (b[7:5] == 3'b110) begin
            cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            cont_left   = 2'd2;
            seq_pos     = STEP_SECOND;
            lead_was_ef = (b == C_LEAD_FW);
        end else if (b[7:3] == 5'b11110) begin
            cont_left = 2'd3;
        end
        if (ch != 0 && kept_so_far < kept_limit) begin
            kept_so_far = kept_so_far + 1'b1;
            r = '{is_end: 1'b0, kept_count: kept_so_far, out_char: ch};
            cleaned_q.push_back(r);
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic eos);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        clean_byte(b, eos);
        words_sent++;
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (cleaned_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_kept(input logic [COUNT_W-1:0] value);
        wait_idle();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        kept_limit = value;
        i_cfg_wen <= 1'b0;
    endtask

    task automatic test_ascii();
        logic [7:0] seq [9] = '{8'h30, 8'h39, 8'h2B, 8'h23, 8'h2A, 8'h3B, 8'h2C, 8'h00, 8'h41};
        foreach (seq[i])
            send_word(seq[i], 1'b0);
        send_word(8'($urandom), 1'b1);
    endtask

    // fullwidth digit, other multibyte, strays, terminator inside a char
    task automatic test_multibyte();
        logic [7:0] seq [15] = '{C_LEAD_FW, C_SECOND_FW, 8'h99, C_LEAD_FW, C_SECOND_HALF, 8'h90,
                                 8'hC3, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hF8,
                                 C_LEAD_FW};
        foreach (seq[i])
            send_word(seq[i], 1'b0);
        send_word(C_SECOND_FW, 1'b0);
        send_word(8'hFF, 1'b1);
    endtask

    task automatic test_limit();
        set_max_kept(12'd1);
        send_word(8'h35, 1'b0);
        send_word(8'h36, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    task automatic send_random_char();
        int                pick;
        int                r;
        int                n;
        logic [7:0]        lead;
        logic [7:0]        third;
        logic [CHAR_W-1:0] asc;
        pick = $urandom_range(99);
        r    = $urandom_range(14);
        case (r)
            10:      begin asc = C_ASC_PLUS;  third = C_FW_PLUS;  end
            11:      begin asc = C_ASC_STAR;  third = C_FW_STAR;  end
            12:      begin asc = C_ASC_HASH;  third = C_FW_HASH;  end
            13:      begin asc = C_ASC_COMMA; third = C_FW_COMMA; end
            14:      begin asc = C_ASC_SEMI;  third = C_FW_SEMI;  end
            default: begin
                asc   = C_ASC_ZERO + 7'(r);
                third = C_FW_DIGIT_LO + 8'(r);
            end
        endcase
        if (pick < 35) begin
            send_word({1'b0, asc}, 1'b0);
        end else if (pick < 60) begin
            send_word(C_LEAD_FW, 1'b0);
            send_word(C_SECOND_FW, 1'b0);
            send_word(third, 1'b0);
        end else if (pick < 67) begin
            send_word(C_LEAD_FW, 1'b0);
            send_word(C_SECOND_FW, 1'b0);
            send_word(8'($urandom), 1'b0);
        end else if (pick < 73) begin
            lead = $urandom_range(1) ? C_LEAD_FW : {4'b1110, 4'($urandom)};
            send_word(lead, 1'b0);
            send_word($urandom_range(1) ? C_SECOND_HALF : 8'($urandom), 1'b0);
            send_word(third, 1'b0);
        end else if (pick < 80) begin
            send_word({1'b0, 7'($urandom)}, 1'b0);
        end else if (pick < 88) begin
            n = $urandom_range(1, 3);
            lead = (n == 1) ? {3'b110, 5'($urandom)} :
                   (n == 2) ? {4'b1110, 4'($urandom)} : {5'b11110, 3'($urandom)};
            send_word(lead, 1'b0);
            repeat (n) send_word(8'($urandom), 1'b0);
        end else if (pick < 95) begin
            send_word(8'($urandom), 1'b0);
        end else begin
            // truncated sequence
            send_word(C_LEAD_FW, 1'b0);
            if ($urandom_range(1))
                send_word(C_SECOND_FW, 1'b0);
        end
    endtask

    task automatic test_random();
        int start;
        start = words_sent;
        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       ;
                1:       set_max_kept(12'd1);
                2:       set_max_kept(12'hFFF);
                3:       set_max_kept(12'd2);
                4:       set_max_kept(12'($urandom_range(3, 40)));
                default: set_max_kept(12'($urandom_range(1, 4095)));
            endcase
            steady = (p == 2);
            while (words_sent - start < (p + 1) * RANDOM_ITEMS / 7) begin
                repeat ($urandom_range(0, 30)) send_random_char();
                send_word(8'($urandom), 1'b1);
                if ($urandom_range(39) == 0)
                    wait_idle();
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        clear_seq();
        kept_so_far = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_ascii();
        test_multibyte();
        test_limit();
        test_random();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && cleaned_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    always @(posedge i_clk)
        i_m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (cleaned_q.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCH)
                    $display("unexpected word: char %h count %0d end %b",
                             o_m_axis_tdata[6:0], o_m_axis_tdata[18:7], o_m_axis_tlast);
            end else begin
                want = cleaned_q.pop_front();
                if ({o_m_axis_tlast, o_m_axis_tdata} !==
                    {want.is_end, 5'b0, want.kept_count, want.out_char}) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCH)
                        $display("mismatch: want char %h count %0d end %b, got tdata %h end %b",
                                 want.out_char, want.kept_count, want.is_end,
                                 o_m_axis_tdata, o_m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule

[sim.f]
design/dsc_pkg.sv
design/dsc_decode.sv
design/dsc_out_stage.sv
design/dial_string_cleaner.sv
dv/tb_top.sv
